>>> sv/spr_pkg.sv
// shared types, constants and mixing function for the seeded password rotate hash
package spr_pkg;

    localparam int unsigned HASH_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ROT_W       = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic [HASH_W-1:0] seed;
        logic [BYTE_W-1:0] pw_byte;
        logic              use_byte;
        logic              start;
        logic              last;
    } t_item;

    // mix one byte into the hash, then rotate left by the hash's low bits
    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h_in,
        input logic [BYTE_W-1:0] prev,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0]   x;
        logic [HASH_W-1:0]   bw;
        logic [HASH_W-1:0]   h;
        logic [2*HASH_W-1:0] dbl;
        x   = {prev, {(HASH_W-2*BYTE_W){1'b0}}, b};
        bw  = {{(HASH_W-BYTE_W){1'b0}}, b};
        h   = h_in ^ x;
        h   = h + x;
        h   = h ^ (bw << 8);
        h   = h - (bw << 16);
        h   = h ^ (bw << 24);
        dbl = {h, h} << h[ROT_W-1:0];
        return dbl[2*HASH_W-1:HASH_W];
    endfunction

endpackage

>>> sv/spr_front.sv
// front end: accepts input transactions, marks string starts and usable bytes
module spr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_seed,
    input  logic [7:0]             i_pw_byte,
    input  logic                   i_has_byte,
    input  logic                   i_is_last,
    output logic                   o_push,
    output spr_pkg::t_item         o_item,
    input  logic                   i_full
);

    logic r_mid;
    logic n_mid;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // classify the transaction
    always_comb begin
        o_item.seed     = i_seed;
        o_item.pw_byte  = i_pw_byte;
        o_item.use_byte = i_has_byte && (i_pw_byte != '0);
        o_item.start    = !r_mid;
        o_item.last     = i_is_last;
    end

    // track whether a string is open
    always_comb begin
        n_mid = r_mid;
        if (accept) begin
            n_mid = !i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else begin
            r_mid <= n_mid;
        end
    end

endmodule

>>> sv/spr_queue.sv
// short fifo between front and back ends
module spr_queue #(
    parameter int unsigned DEPTH = spr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spr_pkg::t_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    spr_pkg::t_item r_slot [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

>>> sv/spr_back.sv
// back end: runs the hash update and holds the result register
module spr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  spr_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_hash_value
);

    logic [spr_pkg::HASH_W-1:0] r_hash;
    logic [spr_pkg::BYTE_W-1:0] r_prev;
    logic                       r_out_valid;
    logic [spr_pkg::HASH_W-1:0] r_out;
    logic [spr_pkg::HASH_W-1:0] n_hash;
    logic [spr_pkg::BYTE_W-1:0] n_prev;
    logic [spr_pkg::HASH_W-1:0] base_hash;
    logic [spr_pkg::BYTE_W-1:0] base_prev;

    assign o_pop        = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    // string start reloads from seed, then a usable byte is mixed in
    always_comb begin
        base_hash = i_item.start ? i_item.seed : r_hash;
        base_prev = i_item.start ? '0 : r_prev;
        n_hash    = base_hash;
        n_prev    = base_prev;
        if (i_item.use_byte) begin
            n_hash = spr_pkg::mix_byte(base_hash, base_prev, i_item.pw_byte);
            n_prev = i_item.pw_byte;
        end
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_prev <= '0;
        end else if (o_pop) begin
            r_hash <= n_hash;
            r_prev <= n_prev;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out <= n_hash;
        end
    end

`ifndef SYNTH
    // a finished string always shows a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> r_out_valid)
        else $error("last transaction gave no result");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !o_pop)
        else $error("pending result overwritten");

    // an empty password hashes to its seed
    a_empty_is_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.start && !i_item.use_byte && i_item.last
        |=> r_out == $past(i_item.seed))
        else $error("empty password did not give the seed");
`endif

endmodule

>>> sv/seeded_password_rotate_hash.sv
// top level of the seeded password rotate hash
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------------------
//  input   | i_valid | o_ready | i_seed, i_pw_byte, i_has_byte, i_is_last
//  output  | o_valid | i_ready | o_hash_value
//
// one input transaction per cycle while o_ready is high; the hash update is one
// registered step in the back end: a last byte goes into the fifo, is popped once
// earlier entries and any waiting result are taken, and its hash is registered.
// the fifo between front and back (QUEUE_DEPTH entries) absorbs output stalls;
// o_ready drops only once it is full.
// reset is synchronous, active low, and empties the fifo and the result register.
module seeded_password_rotate_hash #(
    parameter int unsigned QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seed,
    input  logic [7:0]  i_pw_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value
);

    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    spr_pkg::t_item front_item;
    spr_pkg::t_item back_item;

    // accept and classify
    spr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_seed     (i_seed),
        .i_pw_byte  (i_pw_byte),
        .i_has_byte (i_has_byte),
        .i_is_last  (i_is_last),
        .o_push     (push),
        .o_item     (front_item),
        .i_full     (full)
    );

    // decoupling fifo
    spr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (back_item)
    );

    // hash and result
    spr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_item       (back_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
